/* design/sfr_pkg.sv */
// ---------------------------------------------------------------------------
// Serial frame receiver package
// Frame byte codes, length limits and the parser phase type.
// ---------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned MAX_FRAME_LEN = 18;

  localparam logic [7:0] START_BYTE = 8'h55;
  localparam logic [7:0] MIN_LEN    = 8'h02;
  localparam logic [7:0] MAX_LEN    = 8'(MAX_FRAME_LEN);
  localparam logic [7:0] ZERO_BYTE  = 8'h00;
  localparam logic [7:0] END_BYTE   = 8'hAA;

  // Stored positions that make up the target word, and the length byte slot.
  localparam logic [4:0] LEN_POS    = 5'd2;
  localparam logic [4:0] TGT_FIRST  = 5'd3;
  localparam logic [4:0] TGT_LAST   = 5'd6;

  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_END     = 2'd3
  } phase_e;

endpackage

/* design/serial_frame_receiver.sv */
// ---------------------------------------------------------------------------
// Serial frame receiver
// Parses start/header/length/payload/zero/end frames from received bytes.
// ---------------------------------------------------------------------------
// Usage: each input item is either a received byte (command 0) or a request
// from software to clear the held-frame flag (command 1). The block takes one
// item per cycle while in_ready_o is high; the per-byte parser update is a
// single short step between the state registers and the result register.
// An end byte produces one result item in the cycle after it is accepted: the
// big-endian target word from stored positions 3..6 and end_ok, which is set
// when the end byte was 0xAA and the frame is now held. All other items give
// no result. While a frame is held, start bytes are ignored.
// The result sits in an output register; the input side stays ready while
// that register is empty or being drained, so a stalled receiver stops all
// input while a result is waiting, even items that would give no result. In
// practice input stalls only while out_ready_i is low and a result is held.
// Reset puts the parser in idle, clears the held flag and zeroes the stored
// target bytes; no result is pending after reset.
// ---------------------------------------------------------------------------
module serial_frame_receiver
  import sfr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] target_position_o,
  output logic               end_ok_o
);

  phase_e       phase_q, phase_d;
  logic [4:0]   byte_pos_q, byte_pos_d;
  logic [4:0]   frame_len_q, frame_len_d;
  logic         frame_held_q, frame_held_d;
  logic [7:0]   tgt_q [4];
  logic [7:0]   tgt_d [4];
  logic         out_valid_q, out_valid_d;
  logic [31:0]  target_q, target_d;
  logic         end_ok_q, end_ok_d;

  logic         in_fire;
  logic         is_byte;
  logic         len_ok;
  logic [4:0]   pos_off;
  logic         pos_is_tgt;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_byte    = in_fire && (command_i == CMD_BYTE);
  assign len_ok     = (rx_byte_i >= MIN_LEN) && (rx_byte_i <= MAX_LEN);
  assign pos_off    = byte_pos_q - TGT_FIRST;
  assign pos_is_tgt = (byte_pos_q >= TGT_FIRST) && (byte_pos_q <= TGT_LAST);

  // Next parser phase.
  always_comb begin
    phase_d = phase_q;
    if (is_byte) begin
      case (phase_q)
        PH_IDLE: begin
          if (rx_byte_i == START_BYTE && !frame_held_q) phase_d = PH_HEADER;
        end
        PH_HEADER: begin
          if (byte_pos_q == LEN_POS) phase_d = len_ok ? PH_PAYLOAD : PH_IDLE;
        end
        PH_PAYLOAD: begin
          if (byte_pos_q >= frame_len_q) begin
            phase_d = (rx_byte_i == ZERO_BYTE) ? PH_END : PH_IDLE;
          end
        end
        PH_END:  phase_d = PH_IDLE;
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  // Data path: position counter, stored bytes, held flag and result.
  always_comb begin
    logic keep;
    keep         = 1'b0;
    byte_pos_d   = byte_pos_q;
    frame_len_d  = frame_len_q;
    frame_held_d = frame_held_q;
    tgt_d        = tgt_q;
    target_d     = target_q;
    end_ok_d     = end_ok_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    if (in_fire && command_i == CMD_CLEAR) begin
      frame_held_d = 1'b0;
    end else if (is_byte) begin
      case (phase_q)
        PH_IDLE: begin
          if (rx_byte_i == START_BYTE && !frame_held_q) byte_pos_d = '0;
        end
        PH_HEADER: begin
          if (byte_pos_q != LEN_POS) begin
            keep = 1'b1;
          end else if (len_ok) begin
            frame_len_d = rx_byte_i[4:0];
          end
        end
        PH_PAYLOAD: begin
          if (byte_pos_q < frame_len_q) keep = 1'b1;
        end
        PH_END: begin
          if (rx_byte_i == END_BYTE) frame_held_d = 1'b1;
          target_d    = {tgt_q[0], tgt_q[1], tgt_q[2], tgt_q[3]};
          end_ok_d    = (rx_byte_i == END_BYTE);
          out_valid_d = 1'b1;
        end
        default: ;
      endcase
    end

    if (keep) begin
      if (pos_is_tgt) tgt_d[pos_off[1:0]] = rx_byte_i;
      byte_pos_d = byte_pos_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      byte_pos_q   <= '0;
      frame_len_q  <= '0;
      frame_held_q <= 1'b0;
      tgt_q        <= '{default: '0};
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      byte_pos_q   <= byte_pos_d;
      frame_len_q  <= frame_len_d;
      frame_held_q <= frame_held_d;
      tgt_q        <= tgt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q <= target_d;
    end_ok_q <= end_ok_d;
  end

  assign out_valid_o       = out_valid_q;
  assign target_position_o = signed'(target_q);
  assign end_ok_o          = end_ok_q;

  // An accepted end byte always produces a result in the next cycle.
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_byte && phase_q == PH_END) |=> out_valid_o)
    else $error("end byte did not produce a result");

  // A clear request leaves no frame held.
  a_clear_drops_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && command_i == CMD_CLEAR) |=> !frame_held_q)
    else $error("held flag survived a clear request");

  // A start byte must not open a frame while one is held.
  a_held_blocks_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_byte && phase_q == PH_IDLE && frame_held_q) |=> phase_q == PH_IDLE)
    else $error("frame started while another was held");

  // The payload counter never runs past the accepted length.
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (byte_pos_q <= frame_len_q))
    else $error("payload position beyond frame length");

endmodule

/* tb/sv/serial_frame_receiver_test.sv */
// ---------------------------------------------------------------------------
// Serial frame receiver testbench
// Sends received bytes and clear requests, predicts every target word and
// end flag from its own parser copy, and checks each result item in order.
// ---------------------------------------------------------------------------
module serial_frame_receiver_test
  import sfr_pkg::*;
();

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned ITEMS_PER_MODE = 320;

  typedef struct packed {
    logic signed [31:0] position;
    logic               end_ok;
  } target_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               command_i = CMD_BYTE;
  logic [7:0]         rx_byte_i = 8'h00;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] target_position_o;
  logic               end_ok_o;

  // Parser copy used to predict the results.
  phase_e     track_phase;
  logic [4:0] track_pos;
  logic [4:0] track_len;
  logic       track_held;
  logic [7:0] track_target [4];

  target_t     pending_targets [$];
  int unsigned useful_items;
  int unsigned mismatch_count;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  logic        hold_off_req = 1'b0;

  serial_frame_receiver i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .target_position_o (target_position_o),
    .end_ok_o          (end_ok_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic void store_frame_byte(input logic [7:0] b);
    logic [4:0] slot;
    slot = track_pos - TGT_FIRST;
    if (track_pos >= TGT_FIRST && track_pos <= TGT_LAST) begin
      track_target[slot[1:0]] = b;
    end
    track_pos = track_pos + 5'd1;
  endfunction

  // Advances the parser copy by one accepted item and queues any result.
  function automatic void parse_item(input logic cmd, input logic [7:0] b);
    if (cmd == CMD_CLEAR) begin
      track_held = 1'b0;
      useful_items++;
      return;
    end
    if (track_phase != PH_IDLE || (b == START_BYTE && !track_held)) begin
      useful_items++;
    end
    case (track_phase)
      PH_IDLE: begin
        if (b == START_BYTE && !track_held) begin
          track_phase = PH_HEADER;
          track_pos = 5'd0;
        end
      end
      PH_HEADER: begin
        if (track_pos != LEN_POS) begin
          store_frame_byte(b);
        end else if (b >= MIN_LEN && b <= MAX_LEN) begin
          track_len = b[4:0];
          track_phase = PH_PAYLOAD;
        end else begin
          track_phase = PH_IDLE;
        end
      end
      PH_PAYLOAD: begin
        if (track_pos < track_len) begin
          store_frame_byte(b);
        end else begin
          track_phase = (b == ZERO_BYTE) ? PH_END : PH_IDLE;
        end
      end
      default: begin
        track_phase = PH_IDLE;
        if (b == END_BYTE) begin
          track_held = 1'b1;
        end
        pending_targets.push_back('{
          position: {track_target[0], track_target[1], track_target[2], track_target[3]},
          end_ok:   (b == END_BYTE)});
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch: %s", what);
    end
  endtask

  // Offers one item, waits for it to be taken, then idles cycle by cycle
  // with the configured chance. Valid is left high when no idle cycle follows.
  task automatic send_item(input logic cmd, input logic [7:0] b);
    in_valid_i <= 1'b1;
    command_i <= cmd;
    rx_byte_i <= b;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    parse_item(cmd, b);
    while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_frame(input int unsigned len, input logic [7:0] zero_b,
                            input logic [7:0] end_b);
    send_item(CMD_BYTE, START_BYTE);
    repeat (2) send_item(CMD_BYTE, 8'($urandom));
    send_item(CMD_BYTE, 8'(len));
    for (int i = 2; i < len; i++) begin
      send_item(CMD_BYTE, 8'($urandom));
    end
    send_item(CMD_BYTE, zero_b);
    send_item(CMD_BYTE, end_b);
  endtask

  // Full target word written, wrong end byte: result comes out, nothing held.
  task automatic test_bad_end_byte();
    send_item(CMD_BYTE, START_BYTE);
    send_item(CMD_BYTE, 8'h12);
    send_item(CMD_BYTE, 8'h34);
    send_item(CMD_BYTE, 8'h07);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'h80);
    repeat (3) send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, ZERO_BYTE);
    send_item(CMD_BYTE, 8'h5A);
  endtask

  // Shortest frame reuses the target bytes of the previous one and is held.
  task automatic test_short_frame_held();
    send_item(CMD_BYTE, START_BYTE);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, MIN_LEN);
    send_item(CMD_BYTE, ZERO_BYTE);
    send_item(CMD_BYTE, END_BYTE);
  endtask

  task automatic test_start_while_held();
    send_item(CMD_BYTE, START_BYTE);
    send_item(CMD_CLEAR, 8'hFF);
  endtask

  task automatic test_bad_length();
    send_item(CMD_BYTE, START_BYTE);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, MAX_LEN + 8'd1);
  endtask

  task automatic test_missing_zero();
    send_item(CMD_BYTE, START_BYTE);
    send_item(CMD_BYTE, END_BYTE);
    send_item(CMD_BYTE, START_BYTE);
    send_item(CMD_BYTE, MIN_LEN);
    send_item(CMD_BYTE, 8'hFF);
  endtask

  // The receiver stops taking results for a long stretch while short frames
  // keep coming, so the output register fills and the input side stalls.
  task automatic test_output_backpressure();
    int unsigned saved_gap;
    saved_gap = send_gap_pct;
    send_gap_pct = 0;
    hold_off_req = 1'b1;
    repeat (12) begin
      if (track_held) begin
        send_item(CMD_CLEAR, 8'h00);
      end
      send_frame(2, ZERO_BYTE, END_BYTE);
    end
    send_gap_pct = saved_gap;
  endtask

  // Mostly well-formed frames with random content; the rest are clear
  // requests, frames with a bad length or no zero byte, and loose bytes.
  task automatic test_random_traffic(input int unsigned item_goal);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  bad_len;
    stop_at = useful_items + item_goal;
    while (useful_items < stop_at) begin
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 3) != 0) ? $urandom_range(2, 8)
                                        : $urandom_range(2, MAX_FRAME_LEN);
      if (track_held && $urandom_range(0, 9) < 8) begin
        send_item(CMD_CLEAR, 8'($urandom));
      end
      if (pick < 65) begin
        send_frame(len, ZERO_BYTE, ($urandom_range(0, 4) != 0) ? END_BYTE : 8'($urandom));
      end else if (pick < 72) begin
        send_item(CMD_CLEAR, 8'($urandom));
      end else if (pick < 80) begin
        bad_len = $urandom_range(0, 1) ? 8'($urandom_range(0, 1))
                                       : 8'($urandom_range(MAX_FRAME_LEN + 1, 255));
        send_item(CMD_BYTE, START_BYTE);
        repeat (2) send_item(CMD_BYTE, 8'($urandom));
        send_item(CMD_BYTE, bad_len);
      end else if (pick < 88) begin
        send_frame(len, 8'($urandom_range(1, 255)), 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) send_item(CMD_BYTE, 8'($urandom));
      end
    end
  endtask

  // Result side: random stalls, or one long hold-off when requested.
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    target_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_targets.size() == 0) begin
        flag_mismatch($sformatf("unexpected result target %h end_ok %b",
                                target_position_o, end_ok_o));
      end else begin
        want = pending_targets.pop_front();
        if (target_position_o !== want.position || end_ok_o !== want.end_ok) begin
          flag_mismatch($sformatf("target exp %h got %h, end_ok exp %b got %b",
                                  want.position, target_position_o, want.end_ok, end_ok_o));
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("** serial_frame_receiver: FAILED **");
    $finish;
  end

  initial begin
    track_phase = PH_IDLE;
    track_pos = 5'd0;
    track_len = 5'd0;
    track_held = 1'b0;
    for (int i = 0; i < 4; i++) begin
      track_target[i] = 8'h00;
    end
    useful_items = 0;
    mismatch_count = 0;
    send_gap_pct = 18;
    recv_stall_pct = 76;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_bad_end_byte();
    test_short_frame_held();
    test_start_while_held();
    test_bad_length();
    test_missing_zero();
    test_output_backpressure();

    test_random_traffic(ITEMS_PER_MODE);
    send_gap_pct = 76;
    recv_stall_pct = 18;
    test_random_traffic(ITEMS_PER_MODE);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    test_random_traffic(ITEMS_PER_MODE);

    in_valid_i <= 1'b0;
    while (pending_targets.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("** serial_frame_receiver: PASSED **");
    end else begin
      $display("** serial_frame_receiver: FAILED **");
    end
    $finish;
  end

endmodule

/* serial_frame_receiver.f */
design/sfr_pkg.sv
design/serial_frame_receiver.sv
tb/sv/serial_frame_receiver_test.sv
